FILE: sv/ght_pkg.sv
package ght_pkg;

	localparam int VALUE_W = 32;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_LOOKUP = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_GEN
	} state_t;

endpackage

FILE: sv/ght_result_reg.sv
module ght_result_reg #(
	parameter int SLOT_W = 6,
	parameter int GEN_W  = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        load,
	input  logic                        res_ok,
	input  logic [SLOT_W-1:0]           res_slot,
	input  logic [GEN_W-1:0]            res_gen,
	input  logic [ght_pkg::VALUE_W-1:0] res_value,
	output logic                        free,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output logic                        ok,
	output logic [SLOT_W-1:0]           handle_slot,
	output logic [GEN_W-1:0]            handle_generation,
	output logic [ght_pkg::VALUE_W-1:0] stored_value
);

	logic                        valid_q;
	logic                        ok_q;
	logic [SLOT_W-1:0]           slot_q;
	logic [GEN_W-1:0]            gen_q;
	logic [ght_pkg::VALUE_W-1:0] value_q;

	assign free = !valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ok_q    <= res_ok;
			slot_q  <= res_slot;
			gen_q   <= res_gen;
			value_q <= res_value;
		end
	end

	assign rsp_valid         = valid_q;
	assign ok                = ok_q;
	assign handle_slot       = slot_q;
	assign handle_generation = gen_q;
	assign stored_value      = value_q;

endmodule

FILE: sv/generational_handle_table_unit.sv
// channel  valid      stall      beat fields
// request  req_valid  req_stall  operation, slot_index, generation, item_value
// response rsp_valid  rsp_stall  ok, handle_slot, handle_generation, stored_value
//
// One item at a time: an item is accepted in IDLE and finishes in EXEC, or in GEN for an add
// that pops the free stack, set by the registered table reads and the generation read after the pop.
// The response register holds the result while the next request is accepted.
// A stalled response holds the item in its last cycle until the register frees.
// Reset empties the free stack and the high-water mark; table contents stay.
module generational_handle_table_unit #(
	parameter int SLOTS    = 64,
	parameter int GEN_BITS = 16,
	localparam int SLOT_W  = $clog2(SLOTS)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  logic [1:0]                  operation,
	input  logic [SLOT_W-1:0]           slot_index,
	input  logic [GEN_BITS-1:0]         generation,
	input  logic [ght_pkg::VALUE_W-1:0] item_value,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output logic                        ok,
	output logic [SLOT_W-1:0]           handle_slot,
	output logic [GEN_BITS-1:0]         handle_generation,
	output logic [ght_pkg::VALUE_W-1:0] stored_value
);

	localparam int CNT_W = $clog2(SLOTS + 1);

	ght_pkg::state_t state_q, state_d;

	ght_pkg::op_t                op_q;
	logic [SLOT_W-1:0]           slot_q;
	logic [GEN_BITS-1:0]         gen_q;
	logic [ght_pkg::VALUE_W-1:0] val_q;

	logic [CNT_W-1:0] free_cnt_q, free_cnt_d;
	logic [CNT_W-1:0] hw_q, hw_d;
	logic [CNT_W-1:0] top_idx;

	logic [GEN_BITS-1:0]         gen_mem [SLOTS];
	logic [ght_pkg::VALUE_W-1:0] val_mem [SLOTS];
	logic [SLOT_W-1:0]           stk_mem [SLOTS];

	logic [GEN_BITS-1:0]         gen_rd_q;
	logic [ght_pkg::VALUE_W-1:0] val_rd_q;
	logic [SLOT_W-1:0]           stk_rd_q;

	logic                        accept;
	logic                        gen_re;
	logic [SLOT_W-1:0]           gen_raddr;
	logic                        gen_we;
	logic [SLOT_W-1:0]           gen_waddr;
	logic [GEN_BITS-1:0]         gen_wdata;
	logic                        val_we;
	logic [SLOT_W-1:0]           val_waddr;
	logic                        stk_we;
	logic [SLOT_W-1:0]           stk_waddr;
	logic                        live;

	logic                        fire;
	logic                        out_free;
	logic                        res_ok;
	logic [SLOT_W-1:0]           res_slot;
	logic [GEN_BITS-1:0]         res_gen;
	logic [ght_pkg::VALUE_W-1:0] res_value;

	assign req_stall = (state_q != ght_pkg::ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign top_idx   = free_cnt_q - CNT_W'(1);
	assign live      = (CNT_W'(slot_q) < hw_q) && (gen_rd_q == gen_q);

	always_comb begin
		state_d    = state_q;
		free_cnt_d = free_cnt_q;
		hw_d       = hw_q;
		gen_re     = accept;
		gen_raddr  = slot_index;
		gen_we     = 1'b0;
		gen_waddr  = slot_q;
		gen_wdata  = gen_rd_q + GEN_BITS'(1);
		val_we     = 1'b0;
		val_waddr  = stk_rd_q;
		stk_we     = 1'b0;
		stk_waddr  = free_cnt_q[SLOT_W-1:0];
		fire       = 1'b0;
		res_ok     = 1'b0;
		res_slot   = '0;
		res_gen    = '0;
		res_value  = '0;
		case (state_q)
			ght_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = ght_pkg::ST_EXEC;
				end
			end
			ght_pkg::ST_EXEC: begin
				case (op_q)
					ght_pkg::OP_ADD: begin
						if (free_cnt_q != '0) begin
							free_cnt_d = top_idx;
							gen_re     = 1'b1;
							gen_raddr  = stk_rd_q;
							val_we     = 1'b1;
							val_waddr  = stk_rd_q;
							state_d    = ght_pkg::ST_GEN;
						end else if (out_free) begin
							fire    = 1'b1;
							state_d = ght_pkg::ST_IDLE;
							if (hw_q < CNT_W'(SLOTS)) begin
								hw_d      = hw_q + CNT_W'(1);
								gen_we    = 1'b1;
								gen_waddr = hw_q[SLOT_W-1:0];
								gen_wdata = GEN_BITS'(1);
								val_we    = 1'b1;
								val_waddr = hw_q[SLOT_W-1:0];
								res_ok    = 1'b1;
								res_slot  = hw_q[SLOT_W-1:0];
								res_gen   = GEN_BITS'(1);
							end
						end
					end
					ght_pkg::OP_REMOVE: begin
						if (out_free) begin
							fire    = 1'b1;
							state_d = ght_pkg::ST_IDLE;
							if (live && (free_cnt_q < CNT_W'(SLOTS))) begin
								gen_we     = 1'b1;
								stk_we     = 1'b1;
								free_cnt_d = free_cnt_q + CNT_W'(1);
								res_ok     = 1'b1;
							end
						end
					end
					ght_pkg::OP_LOOKUP: begin
						if (out_free) begin
							fire    = 1'b1;
							state_d = ght_pkg::ST_IDLE;
							if (live) begin
								res_ok    = 1'b1;
								res_value = val_rd_q;
							end
						end
					end
					ght_pkg::OP_CLEAR: begin
						if (out_free) begin
							fire       = 1'b1;
							state_d    = ght_pkg::ST_IDLE;
							free_cnt_d = '0;
							hw_d       = '0;
							res_ok     = 1'b1;
						end
					end
					default: begin
						state_d = ght_pkg::ST_IDLE;
					end
				endcase
			end
			ght_pkg::ST_GEN: begin
				if (out_free) begin
					fire     = 1'b1;
					state_d  = ght_pkg::ST_IDLE;
					res_ok   = 1'b1;
					res_slot = stk_rd_q;
					res_gen  = gen_rd_q;
				end
			end
			default: begin
				state_d = ght_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ght_pkg::ST_IDLE;
			free_cnt_q <= '0;
			hw_q       <= '0;
		end else begin
			state_q    <= state_d;
			free_cnt_q <= free_cnt_d;
			hw_q       <= hw_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= ght_pkg::op_t'(operation);
			slot_q <= slot_index;
			gen_q  <= generation;
			val_q  <= item_value;
		end
	end

	always_ff @(posedge clk) begin
		if (gen_we) begin
			gen_mem[gen_waddr] <= gen_wdata;
		end
		if (gen_re) begin
			gen_rd_q <= gen_mem[gen_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (val_we) begin
			val_mem[val_waddr] <= val_q;
		end
		if (accept) begin
			val_rd_q <= val_mem[slot_index];
		end
	end

	always_ff @(posedge clk) begin
		if (stk_we) begin
			stk_mem[stk_waddr] <= slot_q;
		end
		if (accept) begin
			stk_rd_q <= stk_mem[top_idx[SLOT_W-1:0]];
		end
	end

	ght_result_reg #(
		.SLOT_W (SLOT_W),
		.GEN_W  (GEN_BITS)
	) u_result (
		.clk               (clk),
		.arst_n            (arst_n),
		.load              (fire),
		.res_ok            (res_ok),
		.res_slot          (res_slot),
		.res_gen           (res_gen),
		.res_value         (res_value),
		.free              (out_free),
		.rsp_valid         (rsp_valid),
		.rsp_stall         (rsp_stall),
		.ok                (ok),
		.handle_slot       (handle_slot),
		.handle_generation (handle_generation),
		.stored_value      (stored_value)
	);

	a_counts_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(free_cnt_q <= CNT_W'(SLOTS)) && (hw_q <= CNT_W'(SLOTS)))
		else $error("free count or high-water mark beyond table size");

	a_accept_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ght_pkg::ST_EXEC))
		else $error("accepted beat not executed next cycle");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		fire |-> !(rsp_valid && rsp_stall))
		else $error("result loaded over a stalled response");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && (state_q == ght_pkg::ST_EXEC) && (op_q == ght_pkg::OP_CLEAR))
		|=> (free_cnt_q == '0) && (hw_q == '0))
		else $error("clear left slots in use");

endmodule

FILE: dv/handle_table_checker.sv
module handle_table_checker #(
	parameter int SLOTS    = 64,
	parameter int GEN_BITS = 16,
	localparam int SLOT_W  = $clog2(SLOTS)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	input  logic                        req_stall,
	input  logic [1:0]                  operation,
	input  logic [SLOT_W-1:0]           slot_index,
	input  logic [GEN_BITS-1:0]         generation,
	input  logic [ght_pkg::VALUE_W-1:0] item_value,
	input  logic                        rsp_valid,
	input  logic                        rsp_stall,
	input  logic                        ok,
	input  logic [SLOT_W-1:0]           handle_slot,
	input  logic [GEN_BITS-1:0]         handle_generation,
	input  logic [ght_pkg::VALUE_W-1:0] stored_value,
	output int                          mismatch_count,
	output int                          pending_beats
);

	typedef struct packed {
		logic                        ok;
		logic [SLOT_W-1:0]           slot;
		logic [GEN_BITS-1:0]         gen;
		logic [ght_pkg::VALUE_W-1:0] value;
	} outcome_t;

	logic [GEN_BITS-1:0]         gen_table [SLOTS];
	logic [ght_pkg::VALUE_W-1:0] value_table [SLOTS];
	logic [SLOT_W-1:0]           free_stack [SLOTS];
	int                          free_count = 0;
	int                          high_water = 0;
	int                          bad_beats = 0;
	outcome_t                    expected_outcomes [$];
	outcome_t                    oldest;

	assign mismatch_count = bad_beats;

	function automatic bit handle_live(logic [SLOT_W-1:0] slot, logic [GEN_BITS-1:0] gen);
		return int'(slot) < high_water && gen_table[slot] == gen;
	endfunction

	function automatic outcome_t table_outcome(ght_pkg::op_t op, logic [SLOT_W-1:0] slot,
			logic [GEN_BITS-1:0] gen, logic [ght_pkg::VALUE_W-1:0] value);
		outcome_t res;
		int       s;
		bit       got;
		res = '0;
		s = 0;
		got = 0;
		case (op)
			ght_pkg::OP_ADD: begin
				if (free_count > 0) begin
					free_count--;
					s = int'(free_stack[free_count]);
					got = 1;
				end else if (high_water < SLOTS) begin
					s = high_water;
					high_water++;
					gen_table[s] = GEN_BITS'(1);
					got = 1;
				end
				if (got) begin
					value_table[s] = value;
					res.ok = 1'b1;
					res.slot = SLOT_W'(s);
					res.gen = gen_table[s];
				end
			end
			ght_pkg::OP_REMOVE: begin
				if (handle_live(slot, gen) && free_count < SLOTS) begin
					gen_table[slot] = gen_table[slot] + GEN_BITS'(1);
					free_stack[free_count] = slot;
					free_count++;
					res.ok = 1'b1;
				end
			end
			ght_pkg::OP_LOOKUP: begin
				if (handle_live(slot, gen)) begin
					res.ok = 1'b1;
					res.value = value_table[slot];
				end
			end
			default: begin
				free_count = 0;
				high_water = 0;
				res.ok = 1'b1;
			end
		endcase
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_outcomes.delete();
			free_count = 0;
			high_water = 0;
			bad_beats = 0;
			pending_beats <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_outcomes.size() == 0) begin
					if (bad_beats < 10)
						$display({"response beat with nothing expected: ",
							"ok=%0b slot=%0d gen=%0d value=%h"},
							ok, handle_slot, handle_generation, stored_value);
					bad_beats++;
				end else begin
					oldest = expected_outcomes.pop_front();
					if (oldest.ok !== ok || oldest.slot !== handle_slot ||
							oldest.gen !== handle_generation ||
							oldest.value !== stored_value) begin
						if (bad_beats < 10)
							$display({"mismatch: expected ok=%0b slot=%0d gen=%0d value=%h, ",
								"got ok=%0b slot=%0d gen=%0d value=%h"},
								oldest.ok, oldest.slot, oldest.gen, oldest.value,
								ok, handle_slot, handle_generation, stored_value);
						bad_beats++;
					end
				end
			end
			if (req_valid && !req_stall)
				expected_outcomes.insert(expected_outcomes.size(),
					table_outcome(ght_pkg::op_t'(operation), slot_index,
					generation, item_value));
			pending_beats <= expected_outcomes.size();
		end
	end

endmodule

FILE: dv/generational_handle_table_unit_test.sv
module generational_handle_table_unit_test;

	localparam int SLOTS        = 64;
	localparam int GEN_BITS     = 16;
	localparam int SLOT_W       = $clog2(SLOTS);
	localparam int RANDOM_ITEMS = 1150;
	localparam int CALM_ITEMS   = 200;
	localparam int POOL_DEPTH   = 128;
	localparam int CYCLE_LIMIT  = 2_000_000;

	typedef struct packed {
		logic [SLOT_W-1:0]   slot;
		logic [GEN_BITS-1:0] gen;
	} handle_t;

	logic                        clk;
	logic                        arst_n;
	logic                        req_valid;
	logic                        req_stall;
	logic [1:0]                  operation;
	logic [SLOT_W-1:0]           slot_index;
	logic [GEN_BITS-1:0]         generation;
	logic [ght_pkg::VALUE_W-1:0] item_value;
	logic                        rsp_valid;
	logic                        rsp_stall;
	logic                        ok;
	logic [SLOT_W-1:0]           handle_slot;
	logic [GEN_BITS-1:0]         handle_generation;
	logic [ght_pkg::VALUE_W-1:0] stored_value;
	int                          mismatch_count;
	int                          pending_beats;
	int                          cycle_count = 0;
	bit                          calm = 0;
	ght_pkg::op_t                issued_ops [$];
	handle_t                     known_handles [$];

	generational_handle_table_unit #(
		.SLOTS    (SLOTS),
		.GEN_BITS (GEN_BITS)
	) u_dut (.*);

	handle_table_checker #(
		.SLOTS    (SLOTS),
		.GEN_BITS (GEN_BITS)
	) u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("generational_handle_table_unit_test failed");
			$finish;
		end
	end

	// collect handles returned by adds for later removes and lookups
	always @(posedge clk) begin
		if (rsp_valid && !rsp_stall && issued_ops.size() != 0) begin
			if (issued_ops.pop_front() == ght_pkg::OP_ADD && ok) begin
				known_handles.insert(known_handles.size(),
					handle_t'({handle_slot, handle_generation}));
				if (known_handles.size() > POOL_DEPTH)
					known_handles.delete(0);
			end
		end
		if (req_valid && !req_stall)
			issued_ops.insert(issued_ops.size(), ght_pkg::op_t'(operation));
	end

	initial begin
		rsp_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!calm) begin
				if ($urandom_range(0, 15) == 0) begin
					repeat ($urandom_range(20, 100)) @(posedge clk);
				end else if ($urandom_range(0, 3) == 0) begin
					rsp_stall <= 1'b1;
					repeat ($urandom_range(1, 16)) @(posedge clk);
					rsp_stall <= 1'b0;
				end
			end
		end
	end

	task automatic drive_item(ght_pkg::op_t op, logic [SLOT_W-1:0] slot,
			logic [GEN_BITS-1:0] gen, logic [ght_pkg::VALUE_W-1:0] value);
		if (!calm && $urandom_range(0, 4) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		req_valid <= 1'b1;
		operation <= op;
		slot_index <= slot;
		generation <= gen;
		item_value <= value;
		@(posedge clk);
		while (req_stall) @(posedge clk);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending_beats != 0) @(posedge clk);
	endtask

	task automatic random_item(int add_pct);
		int                          r;
		handle_t                     h;
		ght_pkg::op_t                op;
		logic [SLOT_W-1:0]           slot;
		logic [GEN_BITS-1:0]         gen;
		logic [ght_pkg::VALUE_W-1:0] value;
		r = int'($urandom_range(0, 99));
		slot = SLOT_W'($urandom);
		gen = GEN_BITS'($urandom);
		value = $urandom;
		if ($urandom_range(0, 15) == 0)
			value = $urandom_range(0, 1) ? '0 : '1;
		if (r == 0) begin
			op = ght_pkg::OP_CLEAR;
		end else if (r <= add_pct) begin
			op = ght_pkg::OP_ADD;
		end else begin
			op = $urandom_range(0, 1) ? ght_pkg::OP_REMOVE : ght_pkg::OP_LOOKUP;
			if (known_handles.size() != 0 && $urandom_range(0, 4) != 0) begin
				h = known_handles[$urandom_range(0, known_handles.size() - 1)];
				slot = h.slot;
				gen = ($urandom_range(0, 5) == 0) ? h.gen + GEN_BITS'(1) : h.gen;
			end else if ($urandom_range(0, 1)) begin
				gen = GEN_BITS'($urandom_range(0, 3));
			end
		end
		drive_item(op, slot, gen, value);
	endtask

	initial begin
		int add_pct;
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		operation <= ght_pkg::OP_ADD;
		slot_index <= '0;
		generation <= '0;
		item_value <= '0;
		add_pct = 50;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table, then stale and doubly freed handles
		drive_item(ght_pkg::OP_LOOKUP, '1, '1, '0);
		drive_item(ght_pkg::OP_REMOVE, '0, GEN_BITS'(1), '1);
		drive_item(ght_pkg::OP_ADD, '0, '0, '1);
		drive_item(ght_pkg::OP_ADD, '1, '1, '0);
		drive_item(ght_pkg::OP_LOOKUP, SLOT_W'(0), GEN_BITS'(1), '0);
		drive_item(ght_pkg::OP_LOOKUP, SLOT_W'(0), GEN_BITS'(2), '0);
		drive_item(ght_pkg::OP_LOOKUP, SLOT_W'(1), GEN_BITS'(1), '1);
		drive_item(ght_pkg::OP_REMOVE, SLOT_W'(0), GEN_BITS'(1), '0);
		drive_item(ght_pkg::OP_LOOKUP, SLOT_W'(0), GEN_BITS'(2), '0);
		drive_item(ght_pkg::OP_REMOVE, SLOT_W'(0), GEN_BITS'(2), '0);
		drive_item(ght_pkg::OP_ADD, '0, '0, 32'h1234_5678);
		drive_item(ght_pkg::OP_ADD, '0, '0, 32'h8765_4321);
		drive_item(ght_pkg::OP_LOOKUP, SLOT_W'(0), GEN_BITS'(3), '0);
		drive_item(ght_pkg::OP_LOOKUP, SLOT_W'(2), GEN_BITS'(1), '0);
		drive_item(ght_pkg::OP_CLEAR, '1, '1, '1);
		drive_item(ght_pkg::OP_LOOKUP, SLOT_W'(0), GEN_BITS'(1), '0);

		// full table, full free stack
		for (int i = 0; i < SLOTS; i++)
			drive_item(ght_pkg::OP_ADD, '0, '0, $urandom);
		drive_item(ght_pkg::OP_ADD, '0, '0, '1);
		for (int i = 0; i < SLOTS; i++)
			drive_item(ght_pkg::OP_REMOVE, SLOT_W'(i), GEN_BITS'(1), '0);
		drive_item(ght_pkg::OP_REMOVE, SLOT_W'(5), GEN_BITS'(2), '0);
		drive_item(ght_pkg::OP_LOOKUP, SLOT_W'(5), GEN_BITS'(2), '0);
		drive_item(ght_pkg::OP_CLEAR, '0, '0, '0);
		drain();

		// cycle one slot through a run of generations
		calm = 1;
		drive_item(ght_pkg::OP_ADD, '0, '0, $urandom);
		for (int g = 1; g < 32; g++) begin
			drive_item(ght_pkg::OP_REMOVE, '0, GEN_BITS'(g), '0);
			drive_item(ght_pkg::OP_ADD, '0, '0, $urandom);
		end
		drive_item(ght_pkg::OP_LOOKUP, '0, GEN_BITS'(32), '0);
		drive_item(ght_pkg::OP_LOOKUP, '0, '0, '0);
		drive_item(ght_pkg::OP_REMOVE, '0, '0, '0);
		drive_item(ght_pkg::OP_LOOKUP, '0, '1, '0);
		drive_item(ght_pkg::OP_CLEAR, '0, '0, '0);
		calm = 0;

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 64 == 0)
				add_pct = 30 + 20 * int'($urandom_range(0, 2));
			if (i == RANDOM_ITEMS / 2)
				drain();
			if (i == RANDOM_ITEMS - CALM_ITEMS)
				calm = 1;
			random_item(add_pct);
		end

		drain();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && pending_beats == 0)
			$display("generational_handle_table_unit_test passed");
		else
			$display("generational_handle_table_unit_test failed");
		$finish;
	end

endmodule

FILE: filelist.f
sv/ght_pkg.sv
sv/ght_result_reg.sv
sv/generational_handle_table_unit.sv
dv/handle_table_checker.sv
dv/generational_handle_table_unit_test.sv
